// File: src/wng_pkg.sv
//------------------------------------------------------------------------------
// wng_pkg
// shared types, widths and helpers of the weighted node gather unit
//------------------------------------------------------------------------------
`default_nettype none

package wng_pkg;

  typedef enum logic [1:0] {
    KIND_NODE  = 2'd0,
    KIND_SLOT  = 2'd1,
    KIND_COUNT = 2'd2,
    KIND_EVAL  = 2'd3
  } kind_t;

  localparam int DEF_MAX_NODES    = 1024;
  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_MAX_SLOTS    = 8;

  localparam int NODE_IDX_W = 10;
  localparam int VTX_IDX_W  = 10;
  localparam int SLOT_W     = 3;
  localparam int CNT_W      = 4;
  localparam int POS_W      = 32;
  localparam int WGT_W      = 16;
  localparam int PROD_W     = POS_W + WGT_W;
  localparam int RND_SH     = 14;

  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 80;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

// File: src/wng_ram.sv
//------------------------------------------------------------------------------
// wng_ram
// simple dual-port synchronous ram, one write and one registered read port
//------------------------------------------------------------------------------
`default_nettype none

module wng_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [wng_pkg::addr_w(DEPTH)-1:0]     waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [wng_pkg::addr_w(DEPTH)-1:0]     raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/weighted_node_gather_unit.sv
//------------------------------------------------------------------------------
// weighted_node_gather_unit
// node position store plus per-vertex influence table; evaluates a vertex as
// the weighted sum of its node positions, rounded and saturated to q16.16
//------------------------------------------------------------------------------
// channel  dir  handshake          payload
// in_      in   tvalid / tready    tuser: kind; tdata: node, vertex, slot,
//                                  count, pos_x, pos_y, weight
// out_     out  tvalid / tready    tuser: saturated; tdata: vertex_id, x, y
//
// node, slot and count writes are taken in the idle state and leave the unit idle
// an evaluation reads the count store, then the single slot-table read port walks
// one influence per cycle into the shared mac; its three-stage pipe drains before
// the round and saturate states
// after reset a clearing pass writes zero to every entry of the count store,
// with in_tready low throughout
// a result waits in the output register; new words are taken meanwhile and
// only the final load of the next evaluation stalls on out_tready
//------------------------------------------------------------------------------
`default_nettype none

module weighted_node_gather_unit #(
  parameter int MAX_NODES    = wng_pkg::DEF_MAX_NODES,
  parameter int MAX_VERTICES = wng_pkg::DEF_MAX_VERTICES,
  parameter int MAX_SLOTS    = wng_pkg::DEF_MAX_SLOTS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // node_index, vertex_index, slot, influence_count, pos_x, pos_y, weight
  input  wire logic [wng_pkg::IN_TDATA_W-1:0]     in_tdata,
  // kind
  input  wire logic [1:0]                         in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // vertex_id, out_x, out_y
  output logic      [wng_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // saturated
  output logic                                    out_tuser
);

  localparam int NODE_AW = wng_pkg::addr_w(MAX_NODES);
  localparam int VTX_AW  = wng_pkg::addr_w(MAX_VERTICES);
  localparam int SLOT_DEPTH = MAX_VERTICES * MAX_SLOTS;
  localparam int SLOT_AW = wng_pkg::addr_w(SLOT_DEPTH);
  localparam int ACC_W   = wng_pkg::PROD_W + wng_pkg::addr_w(MAX_SLOTS);
  localparam int RND_W   = ACC_W - wng_pkg::RND_SH;
  localparam int NODE_W  = 2 * wng_pkg::POS_W;
  localparam int SENT_W  = wng_pkg::NODE_IDX_W + wng_pkg::WGT_W;
  localparam int PAD_W   = wng_pkg::OUT_TDATA_W - wng_pkg::VTX_IDX_W - 2 * wng_pkg::POS_W;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_CNT, S_WALK, S_ROUND, S_SAT} state_t;

  // input fields
  wng_pkg::kind_t                     in_kind;
  logic [wng_pkg::NODE_IDX_W-1:0]     in_node;
  logic [wng_pkg::VTX_IDX_W-1:0]      in_vtx;
  logic [wng_pkg::SLOT_W-1:0]         in_slot;
  logic [wng_pkg::CNT_W-1:0]          in_cnt;
  logic [wng_pkg::POS_W-1:0]          in_x;
  logic [wng_pkg::POS_W-1:0]          in_y;
  logic [wng_pkg::WGT_W-1:0]          in_w;
  logic                               in_acc;
  logic                               vtx_in_rng;

  assign in_kind = wng_pkg::kind_t'(in_tuser);
  assign in_node = in_tdata[9:0];
  assign in_vtx  = in_tdata[19:10];
  assign in_slot = in_tdata[22:20];
  assign in_cnt  = in_tdata[26:23];
  assign in_x    = in_tdata[58:27];
  assign in_y    = in_tdata[90:59];
  assign in_w    = in_tdata[106:91];
  assign in_acc  = in_tvalid && in_tready;
  assign vtx_in_rng = 32'(in_vtx) < MAX_VERTICES;

  state_t                        state_r;
  logic [VTX_AW-1:0]             clr_r;
  logic [wng_pkg::VTX_IDX_W-1:0] vtx_r;
  logic                          vtx_ok_r;
  logic [wng_pkg::CNT_W-1:0]     remain_r;
  logic [SLOT_AW-1:0]            slot_addr_r;
  logic                          v1_r, v2_r, v3_r;
  logic                          nok2_r;
  logic signed [wng_pkg::WGT_W-1:0]  w2_r;
  logic signed [wng_pkg::PROD_W-1:0] prod_x_r, prod_y_r;
  logic signed [ACC_W-1:0]       acc_x_r, acc_y_r;
  logic signed [RND_W-1:0]       rnd_x_r, rnd_y_r;
  logic                          out_valid_r;
  logic [wng_pkg::VTX_IDX_W-1:0] out_vid_r;
  logic [wng_pkg::POS_W-1:0]     out_x_r, out_y_r;
  logic                          out_sat_r;

  // memories
  logic                          node_we, node_re;
  logic [NODE_AW-1:0]            node_waddr, node_raddr;
  logic [NODE_W-1:0]             node_rd;
  logic                          slot_we, slot_re;
  logic [SLOT_AW-1:0]            slot_waddr;
  logic [SENT_W-1:0]             slot_rd;
  logic                          cnt_we, cnt_re;
  logic [VTX_AW-1:0]             cnt_waddr;
  logic [wng_pkg::CNT_W-1:0]     cnt_wdata, cnt_rd, cnt_clamped;

  assign node_we    = in_acc && (in_kind == wng_pkg::KIND_NODE) && (32'(in_node) < MAX_NODES);
  assign node_waddr = NODE_AW'(in_node);
  assign node_re    = v1_r;
  assign node_raddr = NODE_AW'(slot_rd[wng_pkg::NODE_IDX_W-1:0]);

  assign slot_we    = in_acc && (in_kind == wng_pkg::KIND_SLOT) && vtx_in_rng
                      && (32'(in_slot) < MAX_SLOTS);
  assign slot_waddr = SLOT_AW'(32'(in_vtx) * MAX_SLOTS + 32'(in_slot));
  assign slot_re    = (state_r == S_WALK) && (remain_r != '0);

  assign cnt_clamped = (32'(in_cnt) > MAX_SLOTS) ? MAX_SLOTS[wng_pkg::CNT_W-1:0] : in_cnt;
  assign cnt_we    = (state_r == S_CLR)
                     || (in_acc && (in_kind == wng_pkg::KIND_COUNT) && vtx_in_rng);
  assign cnt_waddr = (state_r == S_CLR) ? clr_r : VTX_AW'(in_vtx);
  assign cnt_wdata = (state_r == S_CLR) ? '0 : cnt_clamped;
  assign cnt_re    = in_acc && (in_kind == wng_pkg::KIND_EVAL) && vtx_in_rng;

  wng_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata ({in_y, in_x}),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rd)
  );

  wng_ram #(.WIDTH(SENT_W), .DEPTH(SLOT_DEPTH)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata ({in_w, in_node}),
    .re    (slot_re),
    .raddr (slot_addr_r),
    .rdata (slot_rd)
  );

  wng_ram #(.WIDTH(wng_pkg::CNT_W), .DEPTH(MAX_VERTICES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (VTX_AW'(in_vtx)),
    .rdata (cnt_rd)
  );

  // datapath
  logic signed [wng_pkg::POS_W-1:0]  nx, ny;
  logic signed [wng_pkg::PROD_W-1:0] px, py;
  logic signed [ACC_W-1:0]           sum_x, sum_y;
  logic                              ok_x, ok_y;
  logic [wng_pkg::POS_W-1:0]         sat_x, sat_y;
  logic                              walk_done, out_free;

  assign nx = nok2_r ? node_rd[wng_pkg::POS_W-1:0] : '0;
  assign ny = nok2_r ? node_rd[NODE_W-1:wng_pkg::POS_W] : '0;
  assign px = nx * w2_r;
  assign py = ny * w2_r;

  assign sum_x = acc_x_r + ACC_W'(2 ** (wng_pkg::RND_SH - 1));
  assign sum_y = acc_y_r + ACC_W'(2 ** (wng_pkg::RND_SH - 1));

  assign ok_x = (rnd_x_r[RND_W-1:wng_pkg::POS_W-1] == '0)
                || (&rnd_x_r[RND_W-1:wng_pkg::POS_W-1]);
  assign ok_y = (rnd_y_r[RND_W-1:wng_pkg::POS_W-1] == '0)
                || (&rnd_y_r[RND_W-1:wng_pkg::POS_W-1]);
  assign sat_x = ok_x ? rnd_x_r[wng_pkg::POS_W-1:0]
               : (rnd_x_r[RND_W-1] ? 32'h8000_0000 : 32'h7fff_ffff);
  assign sat_y = ok_y ? rnd_y_r[wng_pkg::POS_W-1:0]
               : (rnd_y_r[RND_W-1] ? 32'h8000_0000 : 32'h7fff_ffff);

  assign walk_done = (remain_r == '0) && !v1_r && !v2_r && !v3_r;
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      remain_r    <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= slot_re;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (v1_r) begin
        w2_r   <= slot_rd[SENT_W-1:wng_pkg::NODE_IDX_W];
        nok2_r <= 32'(slot_rd[wng_pkg::NODE_IDX_W-1:0]) < MAX_NODES;
      end
      if (v2_r) begin
        prod_x_r <= px;
        prod_y_r <= py;
      end
      if (v3_r) begin
        acc_x_r <= acc_x_r + ACC_W'(prod_x_r);
        acc_y_r <= acc_y_r + ACC_W'(prod_y_r);
      end
      if (slot_re) begin
        remain_r    <= remain_r - 1'b1;
        slot_addr_r <= slot_addr_r + 1'b1;
      end
      if ((state_r == S_SAT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == VTX_AW'(MAX_VERTICES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && (in_kind == wng_pkg::KIND_EVAL)) begin
            vtx_r    <= in_vtx;
            vtx_ok_r <= vtx_in_rng;
            acc_x_r  <= '0;
            acc_y_r  <= '0;
            state_r  <= S_CNT;
          end
        end
        S_CNT: begin
          remain_r    <= vtx_ok_r ? cnt_rd : '0;
          slot_addr_r <= SLOT_AW'(32'(vtx_r) * MAX_SLOTS);
          state_r     <= S_WALK;
        end
        S_WALK: begin
          if (walk_done) begin
            state_r <= S_ROUND;
          end
        end
        S_ROUND: begin
          rnd_x_r <= sum_x[ACC_W-1:wng_pkg::RND_SH];
          rnd_y_r <= sum_y[ACC_W-1:wng_pkg::RND_SH];
          state_r <= S_SAT;
        end
        S_SAT: begin
          if (out_free) begin
            out_vid_r   <= vtx_r;
            out_x_r     <= sat_x;
            out_y_r     <= sat_y;
            out_sat_r   <= !ok_x || !ok_y;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {PAD_W'(0), out_y_r, out_x_r, out_vid_r};
  assign out_tuser  = out_sat_r;

endmodule

`default_nettype wire

// File: src/wng_checker.sv
//------------------------------------------------------------------------------
// wng_checker
// port-level checks of the weighted node gather unit, bound to the top level
//------------------------------------------------------------------------------
`default_nettype none

module wng_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [1:0]                      in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [wng_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                            out_tuser
);

  // reset starts the count clearing pass, so no word is taken next cycle
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("word taken or result shown right after reset");

  // an accepted evaluation moves the unit out of the idle state, so in_tready drops
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == wng_pkg::KIND_EVAL) |=> !in_tready)
    else $error("word taken in the cycle after an evaluation");

  // a clipped result carries a range limit in at least one coordinate
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[41:10] == 32'h7fff_ffff) || (out_tdata[41:10] == 32'h8000_0000) ||
      (out_tdata[73:42] == 32'h7fff_ffff) || (out_tdata[73:42] == 32'h8000_0000))
    else $error("saturated flag without a limit value");

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

endmodule

bind weighted_node_gather_unit wng_checker u_wng_checker (.*);

`default_nettype wire

// File: dv/tb_top.sv
//------------------------------------------------------------------------------
// tb_top
// testbench of the weighted node gather unit: a directed table of node, slot,
// count and evaluate words, then random chains that build a vertex's influence
// list and evaluate it, mixed with noise words; each result is checked against
// a pinned value or a predictor with its own node store, slot table and count store
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int     RAND_WORDS = 1900;
  localparam int     MAX_SHOWN  = 10;
  localparam longint Q_MAX      = 64'sd2147483647;
  localparam longint Q_MIN      = -64'sd2147483648;

  typedef struct packed {
    logic [wng_pkg::VTX_IDX_W-1:0] vid;
    logic [wng_pkg::POS_W-1:0]     x;
    logic [wng_pkg::POS_W-1:0]     y;
    logic                          sat;
  } blend_t;

  typedef struct {
    wng_pkg::kind_t                 kind;
    logic [wng_pkg::NODE_IDX_W-1:0] node;
    logic [wng_pkg::VTX_IDX_W-1:0]  vtx;
    logic [wng_pkg::SLOT_W-1:0]     slot;
    logic [wng_pkg::CNT_W-1:0]      cnt;
    logic [wng_pkg::POS_W-1:0]      px;
    logic [wng_pkg::POS_W-1:0]      py;
    logic [wng_pkg::WGT_W-1:0]      wt;
    bit                             fixed;
    blend_t                         res;
  } gather_word_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [wng_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]                      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [wng_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;

  weighted_node_gather_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // predictor state
  logic [wng_pkg::POS_W-1:0]      pred_x   [wng_pkg::DEF_MAX_NODES];
  logic [wng_pkg::POS_W-1:0]      pred_y   [wng_pkg::DEF_MAX_NODES];
  logic [wng_pkg::NODE_IDX_W-1:0] pred_sn  [wng_pkg::DEF_MAX_VERTICES*wng_pkg::DEF_MAX_SLOTS];
  logic [wng_pkg::WGT_W-1:0]      pred_sw  [wng_pkg::DEF_MAX_VERTICES*wng_pkg::DEF_MAX_SLOTS];
  logic [wng_pkg::CNT_W-1:0]      pred_cnt [wng_pkg::DEF_MAX_VERTICES] = '{default: '0};

  // what the stimulus side knows has been written
  bit                             gen_node_ok [wng_pkg::DEF_MAX_NODES];
  bit                             gen_slot_ok [wng_pkg::DEF_MAX_VERTICES*wng_pkg::DEF_MAX_SLOTS];
  logic [wng_pkg::NODE_IDX_W-1:0] gen_slot_node
                                    [wng_pkg::DEF_MAX_VERTICES*wng_pkg::DEF_MAX_SLOTS];
  int                             gen_cnt [wng_pkg::DEF_MAX_VERTICES];
  int                             gen_nodes [$];

  gather_word_t sent_q [$];
  blend_t       blend_q [$];
  gather_word_t directed_tab [21];

  int err_count;
  int words_sent;
  int send_pct;
  int recv_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_pct);
  end

  function automatic logic [wng_pkg::POS_W-1:0] round_clip(input longint acc,
                                                           inout logic clip);
    longint q;
    q = (acc + (64'sd1 <<< (wng_pkg::RND_SH - 1))) >>> wng_pkg::RND_SH;
    if (q > Q_MAX) begin
      clip = 1'b1;
      return Q_MAX[wng_pkg::POS_W-1:0];
    end
    if (q < Q_MIN) begin
      clip = 1'b1;
      return Q_MIN[wng_pkg::POS_W-1:0];
    end
    return q[wng_pkg::POS_W-1:0];
  endfunction

  function automatic void predict_word(input logic [1:0] knd,
                                       input logic [wng_pkg::IN_TDATA_W-1:0] d,
                                       output bit has_res, output blend_t res);
    logic [4:0]                     pad;
    logic [wng_pkg::NODE_IDX_W-1:0] nd;
    logic [wng_pkg::VTX_IDX_W-1:0]  vx;
    logic [wng_pkg::SLOT_W-1:0]     sl;
    logic [wng_pkg::CNT_W-1:0]      c;
    logic [wng_pkg::POS_W-1:0]      px, py;
    logic [wng_pkg::WGT_W-1:0]      wt;
    longint                         ax, ay;
    logic                           clip;
    int                             a;
    {pad, wt, py, px, c, sl, vx, nd} = d;
    has_res = 1'b0;
    res = '0;
    case (wng_pkg::kind_t'(knd))
      wng_pkg::KIND_NODE: begin
        pred_x[nd] = px;
        pred_y[nd] = py;
      end
      wng_pkg::KIND_SLOT: begin
        a = vx * wng_pkg::DEF_MAX_SLOTS + sl;
        pred_sn[a] = nd;
        pred_sw[a] = wt;
      end
      wng_pkg::KIND_COUNT: begin
        pred_cnt[vx] = (c > wng_pkg::DEF_MAX_SLOTS) ?
                       wng_pkg::DEF_MAX_SLOTS[wng_pkg::CNT_W-1:0] : c;
      end
      default: begin
        ax = 0;
        ay = 0;
        clip = 1'b0;
        for (int i = 0; i < pred_cnt[vx]; i++) begin
          a = vx * wng_pkg::DEF_MAX_SLOTS + i;
          ax += longint'($signed(pred_x[pred_sn[a]])) * longint'($signed(pred_sw[a]));
          ay += longint'($signed(pred_y[pred_sn[a]])) * longint'($signed(pred_sw[a]));
        end
        res.vid = vx;
        res.x   = round_clip(ax, clip);
        res.y   = round_clip(ay, clip);
        res.sat = clip;
        has_res = 1'b1;
      end
    endcase
  endfunction

  // input acceptance first, then result check, so ordering within an edge is fixed
  always @(posedge clk) begin : monitor
    gather_word_t w;
    blend_t       exp_r;
    blend_t       got;
    bit           has_res;
    logic [5:0]   opad;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        w = sent_q.pop_front();
        predict_word(in_tuser, in_tdata, has_res, exp_r);
        if (has_res) begin
          blend_q = {blend_q, (w.fixed ? w.res : exp_r)};
        end
      end
      if (out_tvalid && out_tready) begin
        {opad, got.y, got.x, got.vid} = out_tdata;
        got.sat = out_tuser;
        if (blend_q.size() == 0) begin
          err_count++;
          if (err_count <= MAX_SHOWN) begin
            $display("unexpected result: id=%0d x=%h y=%h sat=%0b",
                     got.vid, got.x, got.y, got.sat);
          end
        end else begin
          exp_r = blend_q.pop_front();
          if (got.vid !== exp_r.vid || got.x !== exp_r.x || got.y !== exp_r.y ||
              got.sat !== exp_r.sat) begin
            err_count++;
            if (err_count <= MAX_SHOWN) begin
              $display("mismatch: exp id=%0d x=%h y=%h sat=%0b, got id=%0d x=%h y=%h sat=%0b",
                       exp_r.vid, exp_r.x, exp_r.y, exp_r.sat,
                       got.vid, got.x, got.y, got.sat);
            end
          end
        end
      end
    end
  end

  function automatic gather_word_t mk(wng_pkg::kind_t k, int nd, int vx, int sl, int c,
                                      logic [wng_pkg::POS_W-1:0] px,
                                      logic [wng_pkg::POS_W-1:0] py,
                                      logic [wng_pkg::WGT_W-1:0] wt);
    gather_word_t w;
    w.kind  = k;
    w.node  = nd[wng_pkg::NODE_IDX_W-1:0];
    w.vtx   = vx[wng_pkg::VTX_IDX_W-1:0];
    w.slot  = sl[wng_pkg::SLOT_W-1:0];
    w.cnt   = c[wng_pkg::CNT_W-1:0];
    w.px    = px;
    w.py    = py;
    w.wt    = wt;
    w.fixed = 1'b0;
    w.res   = '0;
    return w;
  endfunction

  function automatic gather_word_t pin(gather_word_t w, int vid,
                                       logic [wng_pkg::POS_W-1:0] x,
                                       logic [wng_pkg::POS_W-1:0] y, bit s);
    w.fixed   = 1'b1;
    w.res.vid = vid[wng_pkg::VTX_IDX_W-1:0];
    w.res.x   = x;
    w.res.y   = y;
    w.res.sat = s;
    return w;
  endfunction

  function automatic logic [wng_pkg::POS_W-1:0] rand_pos();
    logic [wng_pkg::POS_W-1:0] edges [5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                             32'hFFFF_FFFF, 32'h0001_0000};
    case ($urandom_range(0, 3))
      0:       return edges[$urandom_range(0, 4)];
      1:       return wng_pkg::POS_W'($signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [wng_pkg::WGT_W-1:0] rand_wt();
    logic [wng_pkg::WGT_W-1:0] edges [5] = '{16'h7FFF, 16'h8000, 16'h0, 16'hFFFF, 16'h4000};
    case ($urandom_range(0, 3))
      0:       return edges[$urandom_range(0, 4)];
      1:       return wng_pkg::WGT_W'($urandom_range(0, 16'h7FFF) - 16'h4000);
      default: return wng_pkg::WGT_W'($urandom);
    endcase
  endfunction

  function automatic gather_word_t rand_word(wng_pkg::kind_t k);
    return mk(k, $urandom_range(0, wng_pkg::DEF_MAX_NODES - 1),
              $urandom_range(0, wng_pkg::DEF_MAX_VERTICES - 1),
              $urandom_range(0, wng_pkg::DEF_MAX_SLOTS - 1), $urandom_range(0, 15),
              rand_pos(), rand_pos(), rand_wt());
  endfunction

  function automatic bit gen_safe(input logic [wng_pkg::VTX_IDX_W-1:0] v);
    int a;
    for (int i = 0; i < gen_cnt[v]; i++) begin
      a = v * wng_pkg::DEF_MAX_SLOTS + i;
      if (!gen_slot_ok[a] || !gen_node_ok[gen_slot_node[a]]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void note_word(gather_word_t w);
    int a;
    a = w.vtx * wng_pkg::DEF_MAX_SLOTS + w.slot;
    case (w.kind)
      wng_pkg::KIND_NODE: begin
        if (!gen_node_ok[w.node]) gen_nodes = {gen_nodes, int'(w.node)};
        gen_node_ok[w.node] = 1'b1;
      end
      wng_pkg::KIND_SLOT: begin
        gen_slot_ok[a]   = 1'b1;
        gen_slot_node[a] = w.node;
      end
      wng_pkg::KIND_COUNT: begin
        gen_cnt[w.vtx] = (w.cnt > wng_pkg::DEF_MAX_SLOTS) ? wng_pkg::DEF_MAX_SLOTS : w.cnt;
      end
      default: ;
    endcase
  endfunction

  task automatic issue(input gather_word_t w);
    note_word(w);
    sent_q = {sent_q, w};
    while ($urandom_range(0, 99) < send_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, w.wt, w.py, w.px, w.cnt, w.slot, w.vtx, w.node};
    in_tuser  <= w.kind;
    do @(posedge clk); while (in_tready !== 1'b1);
    words_sent++;
  endtask

  // node and slot writes for one vertex, its count, then its evaluation
  task automatic run_chain();
    gather_word_t w;
    int           v;
    int           n;
    int           nd;
    v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                    : $urandom_range(0, wng_pkg::DEF_MAX_VERTICES - 1);
    n = $urandom_range(0, wng_pkg::DEF_MAX_SLOTS);
    for (int i = 0; i < n; i++) begin
      if (gen_nodes.size() == 0 || $urandom_range(0, 1)) begin
        w = rand_word(wng_pkg::KIND_NODE);
        issue(w);
        nd = w.node;
      end else begin
        nd = gen_nodes[$urandom_range(0, gen_nodes.size() - 1)];
      end
      w = rand_word(wng_pkg::KIND_SLOT);
      w.vtx  = v[wng_pkg::VTX_IDX_W-1:0];
      w.slot = i[wng_pkg::SLOT_W-1:0];
      w.node = nd[wng_pkg::NODE_IDX_W-1:0];
      issue(w);
    end
    w = rand_word(wng_pkg::KIND_COUNT);
    w.vtx = v[wng_pkg::VTX_IDX_W-1:0];
    w.cnt = wng_pkg::CNT_W'((n == wng_pkg::DEF_MAX_SLOTS && $urandom_range(0, 1)) ?
            $urandom_range(wng_pkg::DEF_MAX_SLOTS, 15) : n);
    issue(w);
    w = rand_word(wng_pkg::KIND_EVAL);
    w.vtx = v[wng_pkg::VTX_IDX_W-1:0];
    issue(w);
  endtask

  task automatic run_noise();
    gather_word_t w;
    w = rand_word(wng_pkg::kind_t'($urandom_range(0, 3)));
    if (w.kind == wng_pkg::KIND_EVAL && !gen_safe(w.vtx)) begin
      w.kind = wng_pkg::KIND_COUNT;
      w.cnt  = '0;
    end
    issue(w);
  endtask

  initial begin
    bit drained;
    int phase;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    err_count  = 0;
    words_sent = 0;
    send_pct   = 0;
    recv_pct   = 0;
    drained    = 1'b0;
    directed_tab = '{
      pin(mk(wng_pkg::KIND_EVAL, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 1'b0),
      pin(mk(wng_pkg::KIND_EVAL, 0, 1023, 0, 0, 0, 0, 0), 1023, 0, 0, 1'b0),
      mk(wng_pkg::KIND_NODE, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0),
      mk(wng_pkg::KIND_NODE, 1023, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0),
      mk(wng_pkg::KIND_NODE, 1, 0, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 0),
      mk(wng_pkg::KIND_NODE, 2, 0, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 0),
      mk(wng_pkg::KIND_SLOT, 0, 0, 0, 0, 0, 0, 16'h7FFF),
      mk(wng_pkg::KIND_SLOT, 1023, 0, 1, 0, 0, 0, 16'h7FFF),
      mk(wng_pkg::KIND_COUNT, 0, 0, 0, 1, 0, 0, 0),
      pin(mk(wng_pkg::KIND_EVAL, 0, 0, 0, 0, 0, 0, 0), 0, 32'h7FFF_FFFF, 32'h8000_0000,
          1'b1),
      mk(wng_pkg::KIND_COUNT, 0, 0, 0, 2, 0, 0, 0),
      mk(wng_pkg::KIND_EVAL, 0, 0, 0, 0, 0, 0, 0),
      mk(wng_pkg::KIND_SLOT, 1, 1023, 0, 0, 0, 0, 16'h8000),
      mk(wng_pkg::KIND_COUNT, 0, 1023, 0, 1, 0, 0, 0),
      mk(wng_pkg::KIND_EVAL, 0, 1023, 0, 0, 0, 0, 0),
      // rounding ties, one positive and one negative
      mk(wng_pkg::KIND_SLOT, 2, 3, 0, 0, 0, 0, 16'h2000),
      mk(wng_pkg::KIND_COUNT, 0, 3, 0, 1, 0, 0, 0),
      mk(wng_pkg::KIND_EVAL, 0, 3, 0, 0, 0, 0, 0),
      mk(wng_pkg::KIND_COUNT, 0, 0, 0, 0, 0, 0, 0),
      pin(mk(wng_pkg::KIND_EVAL, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 1'b0),
      // count above the slot limit, clipped
      mk(wng_pkg::KIND_COUNT, 0, 1023, 0, 15, 0, 0, 0)
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_tab[i]) issue(directed_tab[i]);

    while (words_sent < $size(directed_tab) + RAND_WORDS) begin
      phase = (words_sent - $size(directed_tab)) * 4 / RAND_WORDS;
      case (phase)
        0:       begin send_pct = 0;  recv_pct = 0;  end
        1:       begin send_pct = 51; recv_pct = 0;  end
        2:       begin send_pct = 0;  recv_pct = 51; end
        default: begin send_pct = 6;  recv_pct = 6;  end
      endcase
      if (!drained && words_sent >= $size(directed_tab) + RAND_WORDS / 2) begin
        drained = 1'b1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (blend_q.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 80) run_chain();
      else run_noise();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (blend_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0 && blend_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/wng_pkg.sv
src/wng_ram.sv
src/weighted_node_gather_unit.sv
src/wng_checker.sv
dv/tb_top.sv
